@@ rtl/crossfader_pot_smoother_macros.svh @@
// Assertion helpers for the crossfader smoother
`ifndef CROSSFADER_POT_SMOOTHER_MACROS_SVH
`define CROSSFADER_POT_SMOOTHER_MACROS_SVH

// same-cycle implication
`define CFPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cfps_pkg.sv @@
package cfps_pkg;

	localparam int SAMPLE_W       = 12;
	localparam int POS_W          = 10;
	localparam int ENTRY_LSB      = SAMPLE_W - POS_W;
	localparam int GAIN_W         = 24;
	localparam int GAIN_FRAC      = 23;
	localparam int WINDOW_LEN_DEF = 16;

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 1'b0;

	localparam logic [POS_W-1:0] POS_MAX       = 10'd1023;
	localparam logic [POS_W-1:0] LAST_SENT_RST = 10'd255;
	localparam logic [POS_W-1:0] THRESHOLD_RST = 10'd2;

	// gain = floor(p * 2^23 / 1023) = (p * ceil(2^43 / 1023)) >> 20, exact for 10-bit p
	localparam int GAIN_SHIFT   = 20;
	localparam int GAIN_K       = GAIN_FRAC + GAIN_SHIFT;
	localparam int GAIN_RECIP_W = 34;
	localparam int GAIN_PROD_W  = POS_W + GAIN_RECIP_W;
	localparam longint unsigned GAIN_RECIP_L =
		((64'd1 << GAIN_K) + 64'(POS_MAX) - 64'd1) / 64'(POS_MAX);
	localparam logic [GAIN_RECIP_W-1:0] GAIN_RECIP = GAIN_RECIP_W'(GAIN_RECIP_L);

	typedef struct packed {
		logic [SAMPLE_W-1:0] pot_sample;
		logic                cut_pressed;
	} sample_t;

	typedef struct packed {
		logic [POS_W-1:0]  fader_position;
		logic [GAIN_W-1:0] gain_b;
		logic [GAIN_W-1:0] gain_a;
	} result_t;

endpackage

@@ rtl/cfps_window.sv @@
module cfps_window #(
	parameter int WINDOW_LEN = cfps_pkg::WINDOW_LEN_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               push,
	input  logic [cfps_pkg::POS_W-1:0]                         entry,
	output logic [cfps_pkg::POS_W+$clog2(WINDOW_LEN)-1:0]      sum
);

	localparam int SumW = cfps_pkg::POS_W + $clog2(WINDOW_LEN);

	// a circular buffer written in order is a shift line: the entry overwritten
	// is always the oldest one, at the last tap
	logic [cfps_pkg::POS_W-1:0] taps_q [WINDOW_LEN];
	logic [SumW-1:0]            sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				taps_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (push) begin
			taps_q[0] <= entry;
			for (int i = 1; i < WINDOW_LEN; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			sum_q <= sum_q - SumW'(taps_q[WINDOW_LEN-1]) + SumW'(entry);
		end
	end

	assign sum = sum_q;

endmodule

@@ rtl/crossfader_pot_smoother.sv @@
// Each accepted sample passes the stage 1, stage 2 and stage 3 (result) registers.
// Throughput: one sample per cycle; stalls only when the result register is held.
// Samples with cut pressed or a change inside the deadband produce no result.
// Reset (arst_n low, async): window and running sum cleared, last sent position 255,
// change threshold 2, pipeline emptied.
module crossfader_pot_smoother #(
	parameter int WINDOW_LEN = cfps_pkg::WINDOW_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB config port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cfps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cfps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cfps_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	// sample channel
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  cfps_pkg::sample_t               sample,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output cfps_pkg::result_t               result
);

	localparam int CntW   = $clog2(WINDOW_LEN);
	localparam int SumW   = cfps_pkg::POS_W + CntW;
	// mean = (sum * ceil(2^MeanK / N)) >> MeanK, exact for every sum below 2^SumW
	localparam int MeanK  = SumW + CntW;
	localparam int RecipW = SumW + 1;
	localparam int ProdW  = SumW + RecipW;
	localparam longint unsigned RecipL =
		((64'd1 << MeanK) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
	localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

	// ---------------- config register ----------------
	logic [cfps_pkg::POS_W-1:0]     thr_q;
	logic [cfps_pkg::CFG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[cfps_pkg::CFG_ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= cfps_pkg::THRESHOLD_RST;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == cfps_pkg::REG_CHANGE_THRESHOLD) begin
			thr_q <= pwdata[cfps_pkg::POS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == cfps_pkg::REG_CHANGE_THRESHOLD) begin
			prdata = cfps_pkg::APB_DATA_W'(thr_q);
		end
	end

	// ---------------- pipeline handshake ----------------
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;
	logic accept;

	assign ready_s3     = !valid_s3 || !result_stall;
	assign ready_s2     = !valid_s2 || ready_s3;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign sample_stall = !ready_s1;
	assign accept       = sample_valid && ready_s1;

	// ---------------- window and running sum ----------------
	logic [SumW-1:0] win_sum;

	cfps_window #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept && !sample.cut_pressed),
		.entry (sample.pot_sample[cfps_pkg::SAMPLE_W-1:cfps_pkg::ENTRY_LSB]),
		.sum   (win_sum)
	);

	// ---------------- stage 1: accepted sample ----------------
	// win_sum already holds this sample's window sum while it sits here
	logic cut_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cut_s1   <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sample_valid;
			cut_s1   <= sample.cut_pressed;
		end
	end

	// ---------------- stage 2: mean product ----------------
	logic             cut_s2;
	logic [ProdW-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cut_s2   <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
			cut_s2   <= cut_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			prod_s2 <= ProdW'(win_sum) * ProdW'(Recip);
		end
	end

	// ---------------- stage 3: deadband, gains, result register ----------------
	logic [cfps_pkg::POS_W-1:0]       mean;
	logic [cfps_pkg::POS_W-1:0]       diff;
	logic [cfps_pkg::POS_W-1:0]       last_sent_q;
	logic                             emit;
	logic [cfps_pkg::GAIN_PROD_W-1:0] gain_b_prod;
	logic [cfps_pkg::GAIN_PROD_W-1:0] gain_a_prod;
	cfps_pkg::result_t                result_s3;

	assign mean = prod_s2[MeanK +: cfps_pkg::POS_W];
	assign diff = (mean > last_sent_q) ? (mean - last_sent_q) : (last_sent_q - mean);
	assign emit = diff > thr_q;

	assign gain_b_prod = cfps_pkg::GAIN_PROD_W'(mean)
		* cfps_pkg::GAIN_PROD_W'(cfps_pkg::GAIN_RECIP);
	assign gain_a_prod = cfps_pkg::GAIN_PROD_W'(cfps_pkg::POS_MAX - mean)
		* cfps_pkg::GAIN_PROD_W'(cfps_pkg::GAIN_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			last_sent_q <= cfps_pkg::LAST_SENT_RST;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2 && !cut_s2 && emit;
			if (valid_s2) begin
				if (cut_s2) begin
					last_sent_q <= '0;
				end else if (emit) begin
					last_sent_q <= mean;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			result_s3.fader_position <= mean;
			result_s3.gain_b <= gain_b_prod[cfps_pkg::GAIN_SHIFT +: cfps_pkg::GAIN_W];
			result_s3.gain_a <= gain_a_prod[cfps_pkg::GAIN_SHIFT +: cfps_pkg::GAIN_W];
		end
	end

	assign result_valid = valid_s3;
	assign result       = result_s3;

endmodule

@@ rtl/cfps_checker.sv @@
`include "crossfader_pot_smoother_macros.svh"

module cfps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [cfps_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [cfps_pkg::APB_DATA_W-1:0] pwdata,
	input logic [cfps_pkg::APB_DATA_W-1:0] prdata,
	input logic                            result_valid,
	input logic                            result_stall,
	input cfps_pkg::result_t               result
);

	// a held result transaction keeps its payload
	`CFPS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

	// the two gains are complementary to within one LSB
	`CFPS_ASSERT_IMPL(a_gain_sum, clk, arst_n, result_valid, (25'(result.gain_a) + 25'(result.gain_b) == 25'd8388608) || (25'(result.gain_a) + 25'(result.gain_b) == 25'd8388607), "gains do not sum to unity")

	// gain_b tracks position * 2^23 / 1023 (8200.0078 per step)
	`CFPS_ASSERT_IMPL(a_gain_b_range, clk, arst_n, result_valid, (32'(result.gain_b) >= 32'(result.fader_position) * 32'd8200) && (32'(result.gain_b) <= 32'(result.fader_position) * 32'd8200 + 32'd16), "gain_b off from position")

	// threshold readback follows the last write
	`CFPS_ASSERT_IMPL(a_thr_readback, clk, arst_n, (psel && penable && pwrite && paddr[cfps_pkg::CFG_ADDR_W-1:2] == cfps_pkg::REG_CHANGE_THRESHOLD) ##1 (paddr[cfps_pkg::CFG_ADDR_W-1:2] == cfps_pkg::REG_CHANGE_THRESHOLD), prdata == 32'($past(pwdata[cfps_pkg::POS_W-1:0])), "threshold readback mismatch")

endmodule

bind crossfader_pot_smoother cfps_checker u_cfps_checker (.*);

@@ bench/crossfader_checker.sv @@
module crossfader_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cfps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cfps_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                            pready,
	input  logic                            sample_valid,
	input  logic                            sample_stall,
	input  cfps_pkg::sample_t               sample,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  cfps_pkg::result_t               result,
	output int                              fail_count,
	output int                              pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH  = cfps_pkg::WINDOW_LEN_DEF;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int SUM_W  = cfps_pkg::POS_W + SLOT_W;

	logic [cfps_pkg::POS_W-1:0] history [DEPTH] = '{default: '0};
	logic [SLOT_W-1:0]          slot = '0;
	logic [SUM_W-1:0]           history_sum = '0;
	logic [cfps_pkg::POS_W-1:0] last_sent_pos = cfps_pkg::LAST_SENT_RST;
	logic [cfps_pkg::POS_W-1:0] deadband = cfps_pkg::THRESHOLD_RST;
	cfps_pkg::result_t          expected_moves [$];
	cfps_pkg::result_t          want;
	int                         fails = 0;

	// floor(pos * 2^23 / 1023), exact in 64 bits
	function automatic logic [cfps_pkg::GAIN_W-1:0] fixed_gain(
		input logic [cfps_pkg::POS_W-1:0] pos);
		logic [63:0] num;
		num = 64'(pos) << cfps_pkg::GAIN_FRAC;
		return cfps_pkg::GAIN_W'(num / 64'(cfps_pkg::POS_MAX));
	endfunction

	task automatic track_sample(input cfps_pkg::sample_t s);
		logic [cfps_pkg::POS_W-1:0] entry;
		logic [cfps_pkg::POS_W-1:0] mean;
		logic [cfps_pkg::POS_W-1:0] gap;
		cfps_pkg::result_t          move;
		if (s.cut_pressed) begin
			last_sent_pos = '0;
			return;
		end
		entry = s.pot_sample[cfps_pkg::SAMPLE_W-1:cfps_pkg::ENTRY_LSB];
		history_sum = history_sum - SUM_W'(history[slot]) + SUM_W'(entry);
		history[slot] = entry;
		slot = (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
		mean = cfps_pkg::POS_W'(history_sum / DEPTH);
		gap = (mean > last_sent_pos) ? mean - last_sent_pos : last_sent_pos - mean;
		if (gap <= deadband)
			return;
		last_sent_pos = mean;
		move.fader_position = mean;
		move.gain_b = fixed_gain(mean);
		move.gain_a = fixed_gain(cfps_pkg::POS_MAX - mean);
		expected_moves.push_back(move);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				history[i] = '0;
			slot = '0;
			history_sum = '0;
			last_sent_pos = cfps_pkg::LAST_SENT_RST;
			deadband = cfps_pkg::THRESHOLD_RST;
			expected_moves.delete();
			pending_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					(paddr >> 2) == cfps_pkg::REG_CHANGE_THRESHOLD)
				deadband = pwdata[cfps_pkg::POS_W-1:0];

			// results first: one from the sample taken this edge cannot be out yet
			if (result_valid && !result_stall) begin
				if (expected_moves.size() == 0) begin
					$display("%0t: unexpected result transaction, got pos %0d gain_b %0d gain_a %0d",
						$time, result.fader_position, result.gain_b, result.gain_a);
					fails++;
				end else begin
					want = expected_moves.pop_front();
					if (result.fader_position !== want.fader_position) begin
						$display("%0t: fader_position expected %0d, got %0d",
							$time, want.fader_position, result.fader_position);
						fails++;
					end
					if (result.gain_b !== want.gain_b) begin
						$display("%0t: gain_b expected %0d, got %0d",
							$time, want.gain_b, result.gain_b);
						fails++;
					end
					if (result.gain_a !== want.gain_a) begin
						$display("%0t: gain_a expected %0d, got %0d",
							$time, want.gain_a, result.gain_a);
						fails++;
					end
				end
			end

			if (sample_valid && !sample_stall)
				track_sample(sample);

			fail_count <= fails;
			pending_count <= expected_moves.size();
		end
	end

endmodule

@@ bench/tb_crossfader_pot_smoother.sv @@
module tb_crossfader_pot_smoother;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cfps_pkg::CFG_ADDR_W-1:0] THRESHOLD_ADDR =
		cfps_pkg::CFG_ADDR_W'(cfps_pkg::REG_CHANGE_THRESHOLD) << 2;
	// first word past the register map, writes there must be dropped
	localparam logic [cfps_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR = THRESHOLD_ADDR + 3'd4;
	localparam int SAMPLE_MAX = (1 << cfps_pkg::SAMPLE_W) - 1;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [cfps_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [cfps_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [cfps_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            sample_valid = 1'b0;
	logic                            sample_stall;
	cfps_pkg::sample_t               sample = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	cfps_pkg::result_t               result;
	int                              fail_count;
	int                              pending_count;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int fader_target = SAMPLE_MAX / 2;

	crossfader_pot_smoother u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	crossfader_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	task automatic apb_write(input logic [cfps_pkg::CFG_ADDR_W-1:0] addr,
			input logic [cfps_pkg::APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// threshold with junk in the unused upper bits
	task automatic set_deadband(input int thr);
		apb_write(THRESHOLD_ADDR, ($urandom() << cfps_pkg::POS_W) | thr);
	endtask

	// hold off the sender until every predicted move is out, then let the pipe empty
	task automatic settle();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_sample(input cfps_pkg::sample_t s);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
	endtask

	// mostly a noisy fader drifting around, with cuts and raw noise mixed in
	function automatic cfps_pkg::sample_t next_sample();
		cfps_pkg::sample_t s;
		int pick;
		int level;
		pick = $urandom_range(99);
		s.cut_pressed = (pick < 8);
		if (pick < 20) begin
			s.pot_sample = cfps_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX));
			return s;
		end
		if ($urandom_range(31) == 0)
			fader_target = $urandom_range(1) ? SAMPLE_MAX : 0;
		else if ($urandom_range(15) == 0)
			fader_target = $urandom_range(SAMPLE_MAX);
		else
			fader_target += int'($urandom_range(160)) - 80;
		if (fader_target < 0)
			fader_target = 0;
		if (fader_target > SAMPLE_MAX)
			fader_target = SAMPLE_MAX;
		level = fader_target + int'($urandom_range(16)) - 8;
		if (level < 0)
			level = 0;
		if (level > SAMPLE_MAX)
			level = SAMPLE_MAX;
		s.pot_sample = cfps_pkg::SAMPLE_W'(level);
		return s;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_sample(next_sample());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 13;
		receiver_stall_pct = 56;

		// reset deadband: lowest entry moves away from the reset position
		send_sample({12'd3, 1'b0});
		// full scale until the whole window is at the top
		for (int i = 0; i < cfps_pkg::WINDOW_LEN_DEF; i++)
			send_sample({12'hFFF, 1'b0});
		send_sample({12'hFFF, 1'b0});
		send_sample({12'hFFF, 1'b1});
		send_sample({12'hFFF, 1'b0});
		send_sample({12'h000, 1'b1});
		send_sample({12'hAAA, 1'b0});
		send_sample({12'h555, 1'b0});

		settle();
		apb_write(UNMAPPED_ADDR, $urandom());
		set_deadband(0);
		run_random(300);

		settle();
		set_deadband(int'(cfps_pkg::POS_MAX));
		run_random(80);

		sender_idle_pct = 56;
		receiver_stall_pct = 13;
		settle();
		set_deadband($urandom_range(1, 24));
		run_random(400);

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		settle();
		set_deadband($urandom_range(25, 300));
		run_random(150);
		settle();
		set_deadband($urandom_range(0, 8));
		run_random(300);

		settle();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
